>>> hdl/vafc_pkg.sv
`timescale 1ns / 1ps
// Package for the vertex attribute to float converter.
// Component type codes, divisors, register indexes and stage records. No dependencies.
package vafc_pkg;

  localparam int unsigned RawW   = 16;
  localparam int unsigned FloatW = 32;
  localparam int unsigned CtypeW = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 3;

  // component type codes
  localparam logic [CtypeW-1:0] TYPE_SBYTE  = 3'd0;
  localparam logic [CtypeW-1:0] TYPE_UBYTE  = 3'd1;
  localparam logic [CtypeW-1:0] TYPE_SSHORT = 3'd2;
  localparam logic [CtypeW-1:0] TYPE_USHORT = 3'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_COMPONENT_TYPE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_NORMALIZED_MODE = 2'd1;

  // normalising divisors, all of the form 2^n - 1
  localparam logic [RawW-1:0] DIV_SBYTE  = 16'd127;
  localparam logic [RawW-1:0] DIV_UBYTE  = 16'd255;
  localparam logic [RawW-1:0] DIV_SSHORT = 16'd32767;
  localparam logic [RawW-1:0] DIV_USHORT = 16'd65535;

  localparam logic [7:0] EXP_BIAS = 8'd127;

  typedef struct packed {
    logic            sign;
    logic [RawW-1:0] mag;
    logic            zero;
    logic            unsup;
    logic            unit;   // normalised magnitude at or above divisor: +/-1.0
    logic            norm;
    logic [1:0]      ctype;
  } s1_t;

  typedef struct packed {
    s1_t       s1;
    logic [3:0] lz;          // leading zeros of mag in 16 bits
  } s2_t;

endpackage

>>> hdl/vertex_attribute_to_float_converter_unit.sv
`timescale 1ns / 1ps
// Top level of the vertex attribute to float converter: config, three-stage pipeline.
// Depends on vafc_pkg and vafc_pack.
//
//   channel  | signals                               | handshake
//   ---------+---------------------------------------+---------------------------
//   input    | raw_component_i                       | valid_i / stall_o
//   output   | float_bits_o                          | valid_o / stall_i
//   config   | cfg_idx_i, cfg_data_i                 | cfg_we_i, no wait
//
// One item per cycle sustained while stall_i is low; the stages (decode,
// leading-zero count, round and pack) are each a register.
// Reset clears the valid bits and sets both config registers to zero.
// A stall holds each stage only while the stage after it is full, so bubbles
// close up and nothing is dropped or repeated.
module vertex_attribute_to_float_converter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vafc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vafc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [vafc_pkg::RawW-1:0]     raw_component_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [vafc_pkg::FloatW-1:0]   float_bits_o
);
  import vafc_pkg::*;

  logic [CtypeW-1:0] ctype_q;
  logic              norm_q;

  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  logic [FloatW-1:0] out_d, out_q;
  logic [RawW-1:0]   div;

  // config registers; the user writes them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctype_q <= '0;
      norm_q  <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_COMPONENT_TYPE) ctype_q <= cfg_data_i;
      if (cfg_idx_i == REG_NORMALIZED_MODE) norm_q <= cfg_data_i[0];
    end
  end

  // a stage loads when it is empty or when the one after it is empty or moving
  assign adv3    = !v3_q || !stall_i;
  assign adv2    = !v2_q || adv3;
  assign adv1    = !v1_q || adv2;
  assign stall_o = !adv1;

  // stage 1: sign and magnitude
  always_comb begin
    s1_d       = '0;
    s1_d.norm  = norm_q;
    s1_d.ctype = ctype_q[1:0];
    s1_d.unsup = (ctype_q > TYPE_USHORT);
    div        = DIV_USHORT;
    case (ctype_q)
      TYPE_SBYTE: begin
        s1_d.sign = raw_component_i[7];
        s1_d.mag  = raw_component_i[7] ? {8'd0, 8'(~raw_component_i[7:0] + 8'd1)}
                                       : {8'd0, raw_component_i[7:0]};
        div       = DIV_SBYTE;
      end
      TYPE_UBYTE: begin
        s1_d.mag  = {8'd0, raw_component_i[7:0]};
        div       = DIV_UBYTE;
      end
      TYPE_SSHORT: begin
        s1_d.sign = raw_component_i[15];
        s1_d.mag  = raw_component_i[15] ? 16'(~raw_component_i + 16'd1) : raw_component_i;
        div       = DIV_SSHORT;
      end
      TYPE_USHORT: begin
        s1_d.mag  = raw_component_i;
        div       = DIV_USHORT;
      end
      default: begin
        s1_d.mag  = '0;
      end
    endcase
    s1_d.zero = (s1_d.mag == '0);
    s1_d.unit = (s1_d.mag >= div);
  end

  // stage 2: leading-zero count
  always_comb begin
    s2_d    = '0;
    s2_d.s1 = s1_q;
    for (int i = 0; i < RawW; i++) begin
      if (s1_q.mag[i]) s2_d.lz = 4'(RawW - 1 - i);
    end
  end

  // stage 3: round and pack
  vafc_pack u_pack (
    .s2_i   (s2_q),
    .bits_o (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) s1_q  <= s1_d;
    if (adv2) s2_q  <= s2_d;
    if (adv3) out_q <= out_d;
  end

  assign valid_o      = v3_q;
  assign float_bits_o = out_q;

endmodule

>>> hdl/vafc_pack.sv
`timescale 1ns / 1ps
// Final stage logic: builds the float pattern, rounding the normalised quotient.
// Depends on vafc_pkg.
module vafc_pack (
  input  vafc_pkg::s2_t            s2_i,
  output logic [vafc_pkg::FloatW-1:0] bits_o
);
  import vafc_pkg::*;

  logic [47:0] rep;
  logic [47:0] rep_sh;
  logic [3:0]  lzn;
  logic [4:0]  nbits;
  logic [23:0] rsum;
  logic [7:0]  nexp;
  logic [RawW-1:0] pmag;
  logic [7:0]  pexp;

  // m/(2^n-1) for 0 < m < 2^n-1 is the n-bit pattern of m repeated without end,
  // so the quotient is exact bit slicing and the tail is never zero: no ties.
  always_comb begin
    rep   = '0;
    nbits = 5'd16;
    case (s2_i.s1.ctype)
      TYPE_SBYTE[1:0]: begin
        nbits = 5'd7;
        rep   = 48'({7{s2_i.s1.mag[6:0]}} >> 1);
      end
      TYPE_UBYTE[1:0]: begin
        nbits = 5'd8;
        rep   = {6{s2_i.s1.mag[7:0]}};
      end
      TYPE_SSHORT[1:0]: begin
        nbits = 5'd15;
        rep   = 48'({4{s2_i.s1.mag[14:0]}} >> 12);
      end
      default: begin
        nbits = 5'd16;
        rep   = {3{s2_i.s1.mag}};
      end
    endcase
    lzn    = 4'(5'(s2_i.lz) - (5'd16 - nbits));
    rep_sh = rep << lzn;
    rsum   = {1'b0, rep_sh[46:24]} + {23'd0, rep_sh[23]};
    nexp   = 8'(8'd126 - {4'd0, lzn}) + {7'd0, rsum[23]};

    pmag = s2_i.s1.mag << s2_i.lz;
    pexp = 8'd142 - {4'd0, s2_i.lz};

    if (s2_i.s1.unsup || s2_i.s1.zero) begin
      bits_o = '0;
    end else if (s2_i.s1.norm && s2_i.s1.unit) begin
      bits_o = {s2_i.s1.sign, EXP_BIAS, 23'd0};
    end else if (s2_i.s1.norm) begin
      bits_o = {s2_i.s1.sign, nexp, rsum[22:0]};
    end else begin
      bits_o = {s2_i.s1.sign, pexp, pmag[14:0], 8'd0};
    end
  end

endmodule
